@@ sv/fqkd_pkg.sv @@
// shared types and constants of the keyed-delete fifo queue
package fqkd_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 16;
   localparam int IN_KEY_BITS      = 16;
   localparam int PRIO_BITS        = 4;
   localparam int OCC_BITS         = 5;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_SERVE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SERVE,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   // strobes from the sequencer to the entry memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   // one result transaction
   typedef struct packed {
      status_type               status;
      logic [IN_KEY_BITS-1:0]   served_key;
      logic [PRIO_BITS-1:0]     served_priority;
      logic [OCC_BITS-1:0]      occupancy;
   } rsp_type;

endpackage

@@ sv/fqkd_channels.sv @@
// request and response channel interfaces
interface fqkd_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [fqkd_pkg::IN_KEY_BITS-1:0]    entry_key;
   logic [fqkd_pkg::PRIO_BITS-1:0]      entry_priority;

   modport source (output valid, output action, output entry_key, output entry_priority,
                   input ready);
   modport sink   (input valid, input action, input entry_key, input entry_priority,
                   output ready);
endinterface

interface fqkd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [fqkd_pkg::IN_KEY_BITS-1:0]    served_key;
   logic [fqkd_pkg::PRIO_BITS-1:0]      served_priority;
   logic [fqkd_pkg::OCC_BITS-1:0]       occupancy;

   modport source (output valid, output status, output served_key, output served_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input served_key, input served_priority,
                   input occupancy, output ready);
endinterface

@@ sv/fqkd_mem.sv @@
// entry memory: one write port, one read port, registered read data
module fqkd_mem #(
   parameter int DEPTH = fqkd_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = fqkd_pkg::KEY_BITS_DEFAULT + fqkd_pkg::PRIO_BITS
) (
   input  logic                      clock,
   input  fqkd_pkg::mem_ctl_type     ctl,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fqkd_seq.sv @@
// sequencer: circular queue pointers, key search and gap compaction
module fqkd_seq #(
   parameter int DEPTH    = fqkd_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = fqkd_pkg::KEY_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   fqkd_req_if.sink                   req_chan,
   output fqkd_pkg::mem_ctl_type      mem_ctl,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic [(KEY_BITS < fqkd_pkg::IN_KEY_BITS ? KEY_BITS : fqkd_pkg::IN_KEY_BITS)
                 + fqkd_pkg::PRIO_BITS - 1:0] mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   input  logic [(KEY_BITS < fqkd_pkg::IN_KEY_BITS ? KEY_BITS : fqkd_pkg::IN_KEY_BITS)
                 + fqkd_pkg::PRIO_BITS - 1:0] mem_rd_data,
   output logic                       res_valid,
   input  logic                       res_ready,
   output fqkd_pkg::rsp_type          res
);

   localparam int SKEY_BITS = (KEY_BITS < fqkd_pkg::IN_KEY_BITS) ? KEY_BITS
                                                                  : fqkd_pkg::IN_KEY_BITS;
   localparam int PB        = fqkd_pkg::PRIO_BITS;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

   fqkd_pkg::state_type      state_ff, state_in;
   fqkd_pkg::action_type     op_ff, op_in;
   logic [SKEY_BITS-1:0]     key_ff, key_in;
   logic [PB-1:0]            prio_ff, prio_in;
   logic [PTR_BITS-1:0]      head_ff, head_in;
   logic [PTR_BITS-1:0]      tail_ff, tail_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [PTR_BITS-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CNT_BITS-1:0]      scan_left_ff, scan_left_in;
   logic [PTR_BITS-1:0]      chk_ptr_ff, chk_ptr_in;
   logic [PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic                     pend_ff, pend_in;
   fqkd_pkg::rsp_type        res_ff, res_in;

   logic [SKEY_BITS-1:0]     rd_key;
   logic [PB-1:0]            rd_prio;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign rd_key  = mem_rd_data[SKEY_BITS+PB-1:PB];
   assign rd_prio = mem_rd_data[PB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqkd_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      prio_ff      <= prio_in;
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      chk_ptr_ff   <= chk_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      res_ff       <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      prio_in      = prio_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      chk_ptr_in   = chk_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      mem_ctl      = '0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_addr  = '0;
      req_chan.ready = 1'b0;
      res_valid    = 1'b0;

      unique case (state_ff)
         fqkd_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = fqkd_pkg::action_type'(req_chan.action);
               key_in   = req_chan.entry_key[SKEY_BITS-1:0];
               prio_in  = req_chan.entry_priority;
               state_in = fqkd_pkg::S_DECODE;
            end
         end

         fqkd_pkg::S_DECODE: begin
            res_in.status          = fqkd_pkg::ST_OK;
            res_in.served_key      = '0;
            res_in.served_priority = '0;
            res_in.occupancy       = fqkd_pkg::OCC_BITS'(count_ff);
            case (op_ff)
               fqkd_pkg::ACT_APPEND: begin
                  state_in = fqkd_pkg::S_DONE;
                  if (count_ff == FULL_CNT) begin
                     res_in.status = fqkd_pkg::ST_FULL;
                  end else begin
                     mem_ctl.wr_en    = 1'b1;
                     mem_wr_addr      = tail_ff;
                     mem_wr_data      = {key_ff, prio_ff};
                     tail_in          = ptr_inc(tail_ff);
                     count_in         = count_ff + CNT_BITS'(1);
                     res_in.occupancy = fqkd_pkg::OCC_BITS'(count_in);
                  end
               end
               fqkd_pkg::ACT_SERVE: begin
                  if (count_ff == '0) begin
                     res_in.status = fqkd_pkg::ST_EMPTY;
                     state_in      = fqkd_pkg::S_DONE;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     mem_rd_addr   = head_ff;
                     state_in      = fqkd_pkg::S_SERVE;
                  end
               end
               default: begin
                  // remove and update both start with a scan from the head
                  if (count_ff == '0) begin
                     res_in.status = fqkd_pkg::ST_EMPTY;
                     state_in      = fqkd_pkg::S_DONE;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     mem_rd_addr   = head_ff;
                     chk_ptr_in    = head_ff;
                     scan_ptr_in   = ptr_inc(head_ff);
                     scan_left_in  = count_ff - CNT_BITS'(1);
                     state_in      = fqkd_pkg::S_SEARCH;
                  end
               end
            endcase
         end

         fqkd_pkg::S_SERVE: begin
            res_in.served_key      = fqkd_pkg::IN_KEY_BITS'(rd_key);
            res_in.served_priority = rd_prio;
            head_in                = ptr_inc(head_ff);
            count_in               = count_ff - CNT_BITS'(1);
            res_in.occupancy       = fqkd_pkg::OCC_BITS'(count_in);
            state_in               = fqkd_pkg::S_DONE;
         end

         fqkd_pkg::S_SEARCH: begin
            if (rd_key == key_ff) begin
               if (op_ff == fqkd_pkg::ACT_UPDATE) begin
                  mem_ctl.wr_en = 1'b1;
                  mem_wr_addr   = chk_ptr_ff;
                  mem_wr_data   = {key_ff, prio_ff};
                  state_in      = fqkd_pkg::S_DONE;
               end else begin
                  wr_ptr_in   = chk_ptr_ff;
                  scan_ptr_in = ptr_inc(chk_ptr_ff);
                  pend_in     = 1'b0;
                  state_in    = fqkd_pkg::S_SHIFT;
               end
            end else if (scan_left_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = scan_ptr_ff;
               chk_ptr_in    = scan_ptr_ff;
               scan_ptr_in   = ptr_inc(scan_ptr_ff);
               scan_left_in  = scan_left_ff - CNT_BITS'(1);
            end else begin
               res_in.status = fqkd_pkg::ST_NOT_FOUND;
               state_in      = fqkd_pkg::S_DONE;
            end
         end

         fqkd_pkg::S_SHIFT: begin
            // read one slot ahead, write the data one slot back
            if (pend_ff) begin
               mem_ctl.wr_en = 1'b1;
               mem_wr_addr   = wr_ptr_ff;
               mem_wr_data   = mem_rd_data;
               wr_ptr_in     = ptr_inc(wr_ptr_ff);
            end
            if (scan_ptr_ff != tail_ff) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = scan_ptr_ff;
               scan_ptr_in   = ptr_inc(scan_ptr_ff);
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  tail_in          = wr_ptr_ff;
                  count_in         = count_ff - CNT_BITS'(1);
                  res_in.occupancy = fqkd_pkg::OCC_BITS'(count_in);
                  state_in         = fqkd_pkg::S_DONE;
               end
            end
         end

         fqkd_pkg::S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = fqkd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fqkd_pkg::S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

@@ sv/fifo_queue_keyed_delete_core.sv @@
// top level of the keyed-delete fifo queue
//
//  channel    dir  handshake      payload
//  req_chan   in   valid/ready    action, entry_key, entry_priority
//  rsp_chan   out  valid/ready    status, served_key, served_priority, occupancy
//
//  append passes S_DECODE and S_DONE on its way to the result register, serve also S_SERVE
//  update and remove scan from the head in S_SEARCH up to the match, remove then shifts the
//  rest up to the tail in S_SHIFT, both one entry per cycle through the single read port
//  reset is synchronous; the queue comes up empty, entry contents are left as they were
//  the result register frees the sequencer, so a new request is taken while a result waits;
//  a second finished result holds in the sequencer until the register drains
module fifo_queue_keyed_delete_core #(
   parameter int DEPTH    = fqkd_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = fqkd_pkg::KEY_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   fqkd_req_if.sink      req_chan,
   fqkd_rsp_if.source    rsp_chan
);

   // stored key is never wider than the incoming key field
   localparam int SKEY_BITS  = (KEY_BITS < fqkd_pkg::IN_KEY_BITS) ? KEY_BITS
                                                                   : fqkd_pkg::IN_KEY_BITS;
   localparam int ENTRY_BITS = SKEY_BITS + fqkd_pkg::PRIO_BITS;
   localparam int PTR_BITS   = $clog2(DEPTH);

   fqkd_pkg::mem_ctl_type    mem_ctl;
   logic [PTR_BITS-1:0]      mem_wr_addr;
   logic [ENTRY_BITS-1:0]    mem_wr_data;
   logic [PTR_BITS-1:0]      mem_rd_addr;
   logic [ENTRY_BITS-1:0]    mem_rd_data;

   logic                     res_valid;
   logic                     res_ready;
   fqkd_pkg::rsp_type        res;

   // output register
   logic                     rsp_valid_ff;
   fqkd_pkg::rsp_type        rsp_data_ff;

   // key and priority entries, arranged as a circular buffer
   fqkd_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // operation sequencer: pointers, scan and compaction
   fqkd_seq #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // register can load when empty or when its transaction leaves this cycle
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_data_ff.status;
   assign rsp_chan.served_key      = rsp_data_ff.served_key;
   assign rsp_chan.served_priority = rsp_data_ff.served_priority;
   assign rsp_chan.occupancy       = rsp_data_ff.occupancy;

endmodule
